### sv/qau_pkg.sv
// Shared types, constants and fixed-point helpers of the quaternion arithmetic unit.
// No dependencies; every other file imports this package.
package qau_pkg;

  localparam int CW   = 16;          // component width
  localparam int FB   = 14;          // fraction bits
  localparam int PW   = 2 * CW;      // product width
  localparam int SW   = PW + 2;      // sum of four products, also sum of squares
  localparam int RW   = SW / 2;      // square root width
  localparam int RMW  = RW + 3;      // square root remainder width
  localparam int DNW  = CW + FB + 2; // divide numerator width
  localparam int CMPW = DNW + RW + 1;
  localparam int SqSteps = RW;
  localparam int DvSteps = CW;
  localparam int QDEPTH  = 2;
  localparam int QAW     = $clog2(QDEPTH);

  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_PROD = 2'd0,
    OP_ROT  = 2'd1,
    OP_NORM = 2'd2,
    OP_CONJ = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } st_e;

  typedef struct packed {
    logic [1:0]           func;
    logic signed [CW-1:0] a_w;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_w;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] r_w;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic [1:0]           status;
  } out_item_t;

  // Index 0 is the scalar part.
  typedef logic [3:0][CW-1:0] quat_t;
  typedef logic [15:0][PW-1:0] prod_t;

  typedef struct packed {
    op_e   op;
    quat_t a;
    quat_t b;
  } q_item_t;

  typedef struct packed {
    quat_t q;
    logic  ovf;
  } ham_t;

  // Round (sum + half) >> FB, then saturate; msb of result flags saturation.
  function automatic logic [CW:0] fix4(input logic signed [PW-1:0] p0,
                                       input logic signed [PW-1:0] p1,
                                       input logic signed [PW-1:0] p2,
                                       input logic signed [PW-1:0] p3);
    logic signed [SW-1:0] s;
    logic [SW-FB-1:0]     t;
    logic [SW-FB-CW:0]    hi;
    logic                 ovf;
    logic [CW-1:0]        v;
    s = SW'(p0) + SW'(p1) + SW'(p2) + SW'(p3) + (SW'(1) << (FB - 1));
    t = s[SW-1:FB];
    hi = t[SW-FB-1:CW-1];
    ovf = !(&hi) && (|hi);
    v = ovf ? (t[SW-FB-1] ? CMIN : CMAX) : t[CW-1:0];
    return {ovf, v};
  endfunction

  // Product term L[i]*R[k], negated per the Hamilton sign and the conjugate of R.
  function automatic logic signed [PW-1:0] trm(input prod_t p, input int i, input int k,
                                               input logic neg, input logic cj);
    logic signed [PW-1:0] v;
    v = $signed(p[4'(4 * i + k)]);
    if (neg ^ (cj && (k != 0))) v = -v;
    return v;
  endfunction

  function automatic ham_t ham4(input prod_t p, input logic cj);
    logic [CW:0] r0, r1, r2, r3;
    ham_t        h;
    r0 = fix4(trm(p, 0, 0, 1'b0, cj), trm(p, 1, 1, 1'b1, cj),
              trm(p, 2, 2, 1'b1, cj), trm(p, 3, 3, 1'b1, cj));
    r1 = fix4(trm(p, 0, 1, 1'b0, cj), trm(p, 1, 0, 1'b0, cj),
              trm(p, 2, 3, 1'b0, cj), trm(p, 3, 2, 1'b1, cj));
    r2 = fix4(trm(p, 0, 2, 1'b0, cj), trm(p, 1, 3, 1'b1, cj),
              trm(p, 2, 0, 1'b0, cj), trm(p, 3, 1, 1'b0, cj));
    r3 = fix4(trm(p, 0, 3, 1'b0, cj), trm(p, 1, 2, 1'b0, cj),
              trm(p, 2, 1, 1'b1, cj), trm(p, 3, 0, 1'b0, cj));
    h.q   = {r3[CW-1:0], r2[CW-1:0], r1[CW-1:0], r0[CW-1:0]};
    h.ovf = r0[CW] | r1[CW] | r2[CW] | r3[CW];
    return h;
  endfunction

endpackage

### sv/qau_front.sv
// Front end: accepts input items, decodes the operation and pushes into the queue.
// Depends on qau_pkg.
module qau_front import qau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      push_o,
  output q_item_t   wdata_o,
  input  logic      full_i
);

  logic    vld_q, vld_d;
  q_item_t itm_q;
  logic    acc;

  assign push_o     = vld_q && !full_i;
  assign in_stall_o = vld_q && full_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign wdata_o    = itm_q;

  always_comb begin
    vld_d = vld_q;
    if (acc) vld_d = 1'b1;
    else if (push_o) vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      itm_q.op <= op_e'(in_item_i.func);
      itm_q.a  <= {in_item_i.a_z, in_item_i.a_y, in_item_i.a_x, in_item_i.a_w};
      itm_q.b  <= {in_item_i.b_z, in_item_i.b_y, in_item_i.b_x, in_item_i.b_w};
    end
  end

endmodule

### sv/qau_queue.sv
// Two-entry queue between front end and execution pipeline.
// Depends on qau_pkg.
module qau_queue import qau_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t wdata_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_item_t rdata_o,
  output logic    empty_o
);

  q_item_t        mem [QDEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QAW:0]   cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wp_q] <= wdata_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count did not advance");

endmodule

### sv/qau_back.sv
// Execution pipeline: products, rotation, conjugate, square root and divide for normalize.
// Depends on qau_pkg; fed by qau_queue.
module qau_back import qau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_item_t   head_i,
  input  logic      head_vld_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int NT = SqSteps + DvSteps;

  typedef struct packed {
    op_e   op;
    quat_t a;
    prod_t p;
  } s1_t;

  typedef struct packed {
    op_e           op;
    quat_t         a;
    quat_t         t;
    logic          f;
    logic [SW-1:0] s;
  } s2_t;

  typedef struct packed {
    op_e           op;
    quat_t         a;
    quat_t         t;
    logic          f;
    logic [SW-1:0] s;
    prod_t         p;
  } s3_t;

  typedef struct packed {
    op_e                   op;
    quat_t                 a;
    quat_t                 res;
    logic                  flg;
    logic [SW-1:0]         sv;
    logic [RMW-1:0]        rem;
    logic [RW-1:0]         root;
    logic [3:0][DNW-1:0]   dr;
    logic [3:0][CW-1:0]    dq;
  } tl_t;

  logic      en;
  logic      v1_q, v2_q, v3_q, ov_q;
  s1_t       s1_q, s1_d;
  s2_t       s2_q, s2_d;
  s3_t       s3_q, s3_d;
  tl_t       tl_q [NT+1];
  logic      tv_q [NT+1];
  tl_t       tl0_d;
  out_item_t out_q, out_d;
  ham_t      h1, h2;

  // Whole pipeline holds while the output register is stalled.
  assign en          = !(ov_q && out_stall_i);
  assign pop_o       = en && head_vld_i;
  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

  // Stage 1: sixteen products L[i]*R[k].
  always_comb begin
    quat_t r;
    logic signed [PW-1:0] pr;
    case (head_i.op)
      OP_ROT:  r = {head_i.b[3], head_i.b[2], head_i.b[1], {CW{1'b0}}};
      OP_NORM: r = head_i.a;
      default: r = head_i.b;
    endcase
    s1_d.op = head_i.op;
    s1_d.a  = head_i.a;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        pr = $signed(head_i.a[i]) * $signed(r[k]);
        s1_d.p[4'(4 * i + k)] = pr;
      end
    end
  end

  // Stage 2: first Hamilton sums, sum of squares.
  always_comb begin
    h1 = ham4(s1_q.p, 1'b0);
    s2_d.op = s1_q.op;
    s2_d.a  = s1_q.a;
    s2_d.t  = h1.q;
    s2_d.f  = h1.ovf;
    s2_d.s  = SW'(s1_q.p[0]) + SW'(s1_q.p[5]) + SW'(s1_q.p[10]) + SW'(s1_q.p[15]);
  end

  // Stage 3: products t[i]*a[k] for the second half of the rotation.
  always_comb begin
    logic signed [PW-1:0] pr;
    s3_d.op = s2_q.op;
    s3_d.a  = s2_q.a;
    s3_d.t  = s2_q.t;
    s3_d.f  = s2_q.f;
    s3_d.s  = s2_q.s;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        pr = $signed(s2_q.t[i]) * $signed(s2_q.a[k]);
        s3_d.p[4'(4 * i + k)] = pr;
      end
    end
  end

  // Stage 4: finish product, rotate and conjugate; seed the square root.
  always_comb begin
    h2 = ham4(s3_q.p, 1'b1);
    tl0_d      = '0;
    tl0_d.op   = s3_q.op;
    tl0_d.a    = s3_q.a;
    tl0_d.sv   = s3_q.s;
    case (s3_q.op)
      OP_PROD: begin
        tl0_d.res = s3_q.t;
        tl0_d.flg = s3_q.f;
      end
      OP_ROT: begin
        tl0_d.res = {h2.q[3], h2.q[2], h2.q[1], {CW{1'b0}}};
        tl0_d.flg = s3_q.f | h2.ovf;
      end
      OP_CONJ: begin
        tl0_d.res[0] = s3_q.a[0];
        for (int k = 1; k < 4; k++) begin
          if (s3_q.a[k] == CMIN) begin
            tl0_d.res[k] = CMAX;
            tl0_d.flg    = 1'b1;
          end else begin
            tl0_d.res[k] = -s3_q.a[k];
          end
        end
      end
      default: begin
        tl0_d.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      tv_q[0]  <= 1'b0;
    end else if (en) begin
      v1_q     <= head_vld_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      tv_q[0]  <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      s3_q    <= s3_d;
      tl_q[0] <= tl0_d;
    end
  end

  // Square root steps, then restoring divide steps for the four lanes.
  for (genvar k = 0; k < NT; k++) begin : g_tl
    tl_t nx;
    if (k < SqSteps) begin : g_sq
      always_comb begin
        logic [RMW-1:0] rn, tr;
        nx = tl_q[k];
        rn = {tl_q[k].rem[RMW-3:0], tl_q[k].sv[SW-1 -: 2]};
        tr = RMW'({tl_q[k].root, 2'b01});
        if (rn >= tr) begin
          nx.rem  = rn - tr;
          nx.root = {tl_q[k].root[RW-2:0], 1'b1};
        end else begin
          nx.rem  = rn;
          nx.root = {tl_q[k].root[RW-2:0], 1'b0};
        end
        nx.sv = tl_q[k].sv << 2;
      end
    end else begin : g_dv
      localparam int B = CW - 1 - (k - SqSteps);
      always_comb begin
        logic [CW-1:0]   mag;
        logic [DNW-1:0]  d;
        logic [CMPW-1:0] dsh;
        nx  = tl_q[k];
        dsh = CMPW'({tl_q[k].root, 1'b0}) << B;
        for (int i = 0; i < 4; i++) begin
          mag = tl_q[k].a[i][CW-1] ? (~tl_q[k].a[i] + 1'b1) : tl_q[k].a[i];
          if (k == SqSteps) begin
            d = DNW'({mag, {(FB+1){1'b0}}}) + DNW'(tl_q[k].root);
          end else begin
            d = tl_q[k].dr[i];
          end
          if (CMPW'(d) >= dsh) begin
            nx.dr[i]    = d - DNW'(dsh);
            nx.dq[i][B] = 1'b1;
          end else begin
            nx.dr[i] = d;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tv_q[k+1] <= 1'b0;
      end else if (en) begin
        tv_q[k+1] <= tv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) tl_q[k+1] <= nx;
    end
  end

  // Last stage: restore signs for normalize, form status.
  always_comb begin
    logic signed [CW:0] v;
    logic               sf;
    out_d = '0;
    sf    = 1'b0;
    if (tl_q[NT].op == OP_NORM) begin
      if (tl_q[NT].root == '0) begin
        out_d.status = ST_ZERO;
      end else begin
        for (int i = 0; i < 4; i++) begin
          v = tl_q[NT].a[i][CW-1] ? -$signed({1'b0, tl_q[NT].dq[i]})
                                  : $signed({1'b0, tl_q[NT].dq[i]});
          if (v[CW] != v[CW-1]) begin
            sf = 1'b1;
            v  = v[CW] ? $signed({1'b1, CMIN}) : $signed({1'b0, CMAX});
          end
          case (i)
            0:       out_d.r_w = v[CW-1:0];
            1:       out_d.r_x = v[CW-1:0];
            2:       out_d.r_y = v[CW-1:0];
            default: out_d.r_z = v[CW-1:0];
          endcase
        end
        out_d.status = sf ? ST_SAT : ST_OK;
      end
    end else begin
      out_d.r_w    = tl_q[NT].res[0];
      out_d.r_x    = tl_q[NT].res[1];
      out_d.r_y    = tl_q[NT].res[2];
      out_d.r_z    = tl_q[NT].res[3];
      out_d.status = tl_q[NT].flg ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= tv_q[NT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q && $stable(out_q)) else $error("output lost under stall");
  a_pop_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !(ov_q && out_stall_i)) else $error("pop while pipeline held");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (out_q.status != 2'd3)) else $error("undefined status code");

endmodule

### sv/quaternion_arith_unit.sv
// Top level of the quaternion arithmetic unit: front end, queue, execution pipeline.
// Depends on qau_pkg, qau_front, qau_queue and qau_back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------
//   input   | in        | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//   output  | out       | out_valid_o/out_stall_i | out_item_o (out_item_t)
//
// One item per cycle sustained while out_stall_i is low; every operation takes the
// same path, so results leave in order.
// Latency is set by the square root (17 stages) and the divide (16 stages) that
// normalize needs; the other operations ride along through those stages.
// Reset clears only valid flags and the queue pointers and count; data registers are not reset.
// An output stall holds the whole execution pipeline; the front end keeps
// accepting until the two-entry queue and its own register are full.
module quaternion_arith_unit import qau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic    push, full, pop, empty;
  q_item_t wdata, rdata;

  // Accept and decode into the queue.
  qau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .wdata_o    (wdata),
    .full_i     (full)
  );

  // Decouple front end from execution.
  qau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rdata),
    .empty_o (empty)
  );

  // Execute and drive the output register.
  qau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (rdata),
    .head_vld_i  (!empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### bench/tb_quaternion_arith_unit.sv
// Testbench for quaternion_arith_unit: directed table, then random items, checked in order
// against typed row values or a fixed-point quaternion predictor. Depends on qau_pkg and the RTL.
`timescale 1ns / 1ps

module tb_quaternion_arith_unit;
  import qau_pkg::*;

  localparam int     NumRandom = 1300;
  localparam longint CycleLimit = 400000;
  localparam longint OneQ = 64'sd1 <<< FB;

  typedef longint quat_l_t [4];

  typedef struct {
    in_item_t  stim;
    bit        typed;   // expected value given in the row
    out_item_t want;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  out_item_t results_due[$];
  int        mismatches = 0;
  longint    cycles = 0;
  bit        quiet = 1'b0;  // no idling on either side while set

  quaternion_arith_unit dut (.*);

  always #4 clk_i = ~clk_i;

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("quaternion_arith_unit verification failed");
      $finish;
    end
  end

  // Receiver backpressure: change at the falling edge only.
  always @(negedge clk_i) begin
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 99) < 31);
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        out_item_t want;
        want = results_due.pop_front();
        if (out_item_o.r_w !== want.r_w || out_item_o.r_x !== want.r_x ||
            out_item_o.r_y !== want.r_y || out_item_o.r_z !== want.r_z ||
            out_item_o.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", want, out_item_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint clamp(input longint v, inout bit ovf);
    longint hi, lo;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin ovf = 1'b1; return hi; end
    if (v < lo) begin ovf = 1'b1; return lo; end
    return v;
  endfunction

  // Exact sum, round to nearest with ties up, then saturate.
  function automatic longint round_sum(input longint p0, p1, p2, p3, inout bit ovf);
    longint s;
    s = p0 + p1 + p2 + p3 + (64'sd1 <<< (FB - 1));
    return clamp(s >>> FB, ovf);
  endfunction

  function automatic void hamilton(input quat_l_t l, input quat_l_t r,
                                   output quat_l_t o, inout bit ovf);
    o[0] = round_sum(l[0]*r[0], -(l[1]*r[1]), -(l[2]*r[2]), -(l[3]*r[3]), ovf);
    o[1] = round_sum(l[0]*r[1], l[1]*r[0], l[2]*r[3], -(l[3]*r[2]), ovf);
    o[2] = round_sum(l[0]*r[2], -(l[1]*r[3]), l[2]*r[0], l[3]*r[1], ovf);
    o[3] = round_sum(l[0]*r[3], l[1]*r[2], -(l[2]*r[1]), l[3]*r[0], ovf);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic out_item_t predict_result(input in_item_t it);
    quat_l_t   a, b, v, t, c, o;
    bit        ovf;
    st_e       st;
    out_item_t r;
    longint unsigned mag, sumsq, len, num;
    longint    m;
    ovf = 1'b0;
    st = ST_OK;
    a = '{longint'(it.a_w), longint'(it.a_x), longint'(it.a_y), longint'(it.a_z)};
    b = '{longint'(it.b_w), longint'(it.b_x), longint'(it.b_y), longint'(it.b_z)};
    o = '{0, 0, 0, 0};
    case (op_e'(it.func))
      OP_PROD: hamilton(a, b, o, ovf);
      OP_ROT: begin
        // rotate as q*v*conj(q); the intermediate saturates too
        v = '{0, b[1], b[2], b[3]};
        hamilton(a, v, t, ovf);
        c = '{a[0], -a[1], -a[2], -a[3]};
        hamilton(t, c, o, ovf);
        o[0] = 0;
      end
      OP_NORM: begin
        sumsq = 0;
        for (int i = 0; i < 4; i++) begin
          mag = a[i] < 0 ? -a[i] : a[i];
          sumsq += mag * mag;
        end
        if (sumsq == 0) begin
          st = ST_ZERO;
        end else begin
          len = root_floor(sumsq);
          for (int i = 0; i < 4; i++) begin
            mag = a[i] < 0 ? -a[i] : a[i];
            num = (mag << FB) * 2 + len;
            m = longint'(num / (2 * len));
            o[i] = clamp(a[i] < 0 ? -m : m, ovf);
          end
        end
      end
      default: begin
        o[0] = a[0];
        for (int i = 1; i < 4; i++) o[i] = clamp(-a[i], ovf);
      end
    endcase
    if (st == ST_OK && ovf) st = ST_SAT;
    r.r_w = o[0][CW-1:0];
    r.r_x = o[1][CW-1:0];
    r.r_y = o[2][CW-1:0];
    r.r_z = o[3][CW-1:0];
    r.status = st;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic in_item_t make_item(input op_e op, input logic [CW-1:0] aw, ax, ay, az,
                                         input logic [CW-1:0] bw, bx, by, bz);
    in_item_t it;
    it.func = op;
    it.a_w = aw; it.a_x = ax; it.a_y = ay; it.a_z = az;
    it.b_w = bw; it.b_x = bx; it.b_y = by; it.b_z = bz;
    return it;
  endfunction

  function automatic out_item_t make_result(input logic [CW-1:0] w, x, y, z, input st_e st);
    out_item_t r;
    r.r_w = w; r.r_x = x; r.r_y = y; r.r_z = z; r.status = st;
    return r;
  endfunction

  // One component: full range, near unit scale, or an extreme.
  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3, 4, 5: return CW'($signed($urandom_range(0, 2 * OneQ)) - OneQ);
      default: return CW'($urandom());
    endcase
  endfunction

  // Drive one item, hold it while stalled, and record its expected result.
  // Valid stays high after acceptance; idle cycles and the caller drop it.
  task automatic send_item(input in_item_t it, input out_item_t want);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 31) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    results_due.push_back(want);
    @(negedge clk_i);
  endtask

  initial begin
    row_t     rows[$];
    row_t     rw;
    in_item_t it;
    longint   wait_cycles;

    // Directed rows; the typed ones are readable at a glance.
    rw.typed = 1'b1;
    rw.stim = make_item(OP_NORM, 0, 0, 0, 0, CMAX, CMIN, 1, 2);
    rw.want = make_result(0, 0, 0, 0, ST_ZERO); rows.push_back(rw);
    rw.stim = make_item(OP_CONJ, CMIN, CMIN, CMIN, CMIN, 0, 0, 0, 0);
    rw.want = make_result(CMIN, CMAX, CMAX, CMAX, ST_SAT); rows.push_back(rw);
    rw.stim = make_item(OP_CONJ, CMAX, CMAX, 1, 0, 0, 0, 0, 0);
    rw.want = make_result(CMAX, CW'(-32767), CW'(-1), 0, ST_OK); rows.push_back(rw);
    rw.stim = make_item(OP_PROD, CW'(OneQ), 0, 0, 0, CW'(OneQ), 0, 0, 0);
    rw.want = make_result(CW'(OneQ), 0, 0, 0, ST_OK); rows.push_back(rw);
    rw.stim = make_item(OP_NORM, CW'(5), 0, 0, 0, 0, 0, 0, 0);
    rw.want = make_result(CW'(OneQ), 0, 0, 0, ST_OK); rows.push_back(rw);
    rw.typed = 1'b0;
    rw.stim = make_item(OP_PROD, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    rows.push_back(rw);
    rw.stim = make_item(OP_PROD, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    rows.push_back(rw);
    rw.stim = make_item(OP_PROD, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN);
    rows.push_back(rw);
    rw.stim = make_item(OP_PROD, 1, 0, 0, 0, CW'(8192), 0, 0, 0); // rounding tie
    rows.push_back(rw);
    rw.stim = make_item(OP_PROD, CW'(-1), 0, 0, 0, CW'(8192), 0, 0, 0);
    rows.push_back(rw);
    rw.stim = make_item(OP_ROT, CW'(OneQ), 0, 0, 0, CMIN, CW'(100), CW'(-200), CW'(300));
    rows.push_back(rw);
    rw.stim = make_item(OP_ROT, CW'(11585), 0, 0, CW'(11585), 0, CW'(OneQ), 0, 0);
    rows.push_back(rw);
    rw.stim = make_item(OP_ROT, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX);
    rows.push_back(rw);
    rw.stim = make_item(OP_ROT, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN);
    rows.push_back(rw);
    rw.stim = make_item(OP_NORM, CMAX, CMAX, CMAX, CMAX, 0, 0, 0, 0);
    rows.push_back(rw);
    rw.stim = make_item(OP_NORM, CMIN, CMIN, CMIN, CMIN, 0, 0, 0, 0);
    rows.push_back(rw);
    rw.stim = make_item(OP_NORM, CMIN, 0, 0, 0, 0, 0, 0, 0);    // most negative scalar, unit result
    rows.push_back(rw);
    rw.stim = make_item(OP_NORM, 1, 1, 1, 1, 0, 0, 0, 0);       // tiny length
    rows.push_back(rw);
    rw.stim = make_item(OP_NORM, CW'(3), CW'(-4), 0, 0, 0, 0, 0, 0);
    rows.push_back(rw);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i])
      send_item(rows[i].stim, rows[i].typed ? rows[i].want : predict_result(rows[i].stim));

    for (int n = 0; n < NumRandom; n++) begin
      quiet = (n >= 400 && n < 600);
      // Pause the sender once until the pipeline has drained.
      if (n == 800) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (results_due.size() != 0) @(negedge clk_i);
      end
      it = make_item(op_e'($urandom_range(0, 3)), rand_comp(), rand_comp(), rand_comp(),
                     rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
      if ($urandom_range(0, 19) == 0) begin
        it.a_w = '0; it.a_x = '0; it.a_y = '0; it.a_z = '0;
      end
      send_item(it, predict_result(it));
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;

    wait_cycles = 0;
    while (results_due.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (60) @(negedge clk_i);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("quaternion_arith_unit verification clean");
    end else begin
      $display("quaternion_arith_unit verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/qau_pkg.sv
sv/qau_front.sv
sv/qau_queue.sv
sv/qau_back.sv
sv/quaternion_arith_unit.sv
bench/tb_quaternion_arith_unit.sv
